>>> hw/rtl/sccbms_pkg.sv
// Shared types and constants for the SCCB master sequencer.
package sccbms_pkg;

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_START_SDA,
		PH_START_SCL,
		PH_START_LOW,
		PH_TX_LOW,
		PH_TX_HIGH,
		PH_ACK_LOW,
		PH_ACK_HIGH,
		PH_RX_LOW,
		PH_RX_HIGH,
		PH_NK_LOW,
		PH_NK_HIGH,
		PH_NK_END,
		PH_NK_SDA,
		PH_STOP_A,
		PH_STOP_B,
		PH_STOP_C
	} phase_t;

	localparam logic [1:0]  CMD_WRITE3 = 2'd0;
	localparam logic [1:0]  CMD_WRITE2 = 2'd1;
	localparam logic [1:0]  CMD_READ   = 2'd2;
	localparam logic [1:0]  CMD_RSVD   = 2'd3;

	localparam logic [15:0] WAIT_RESET = 16'd100;
	localparam logic [2:0]  LAST_BIT   = 3'd7;

	localparam logic [1:0]  BYTE_ID    = 2'd0;
	localparam logic [1:0]  BYTE_SUB   = 2'd1;
	localparam logic [1:0]  BYTE_DATA  = 2'd2;

	typedef struct packed {
		logic       start_request;
		logic [1:0] command;
		logic [6:0] device_id;
		logic [7:0] sub_address;
		logic [7:0] write_data;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
	} result_t;

endpackage

>>> hw/rtl/sccb_master_sequencer_core.sv
// Top level of the SCCB master sequencer: input register, step core, result register.
// Words pass from the input register through the step core into the result register.
// Throughput: one word per cycle unless stalled; the step core runs once per word.
// A full result register that is stalled holds the input register, which then stalls.
// Reset (arst_n low, asynchronous): bus idle, SCL and SDA driven high, both
// pipeline registers empty, wait_ticks back to 100.
module sccb_master_sequencer_core import sccbms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        wait_we,
	input  logic [15:0] wait_data
);

	logic        item_valid_s1;
	item_t       item_s1;
	logic        advance;
	logic [15:0] wait_ticks_q;
	result_t     step_result;

	// Step the core when a word is waiting and the result register can take it
	assign advance    = item_valid_s1 && (!result_valid || !result_stall);
	assign item_stall = item_valid_s1 && !advance;

	// Configured segment length; user writes only while no word is in flight, unchecked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_ticks_q <= WAIT_RESET;
		end else if (wait_we) begin
			wait_ticks_q <= wait_data;
		end
	end

	// Input register: load on accept, drop once the core has consumed it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	sccbms_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.wait_ticks (wait_ticks_q),
		.item       (item_s1),
		.result     (step_result)
	);

	// Result register: advance loads a fresh word, a taken word empties it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= step_result;
		end
	end

endmodule

>>> hw/rtl/sccbms_core.sv
// Bus sequencer state and the one-tick step logic.
module sccbms_core import sccbms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [15:0] wait_ticks,
	input  item_t       item,
	output result_t     result
);

	phase_t      ph_q, ph_n, ph_cur;
	logic [15:0] tc_q, tc_n, tc_inc, hold;
	logic [2:0]  bi_q, bi_n;
	logic [7:0]  sb_q, sb_n, rb_q, rb_n;
	logic [1:0]  hc_q, hc_n, bn_q, bn_n;
	logic [7:0]  hs_q, hs_n, hw_q, hw_n;
	logic        scl_q, scl_n, sda_q, sda_n, en_q, en_n;
	logic        done;

	assign hold = (wait_ticks == '0) ? 16'd1 : wait_ticks;

	always_comb begin
		ph_n   = ph_q;
		tc_n   = tc_q;
		bi_n   = bi_q;
		sb_n   = sb_q;
		rb_n   = rb_q;
		hc_n   = hc_q;
		bn_n   = bn_q;
		hs_n   = hs_q;
		hw_n   = hw_q;
		scl_n  = scl_q;
		sda_n  = sda_q;
		en_n   = en_q;
		done   = 1'b0;
		tc_inc = '0;
		ph_cur = ph_q;

		// latch a new request only while idle
		if (step && ph_q == PH_IDLE && item.start_request && item.command != CMD_RSVD) begin
			hc_n = item.command;
			hs_n = item.sub_address;
			hw_n = item.write_data;
			sb_n = {item.device_id, item.command == CMD_READ};
			bi_n = LAST_BIT;
			bn_n = BYTE_ID;
			if (item.command == CMD_READ) begin
				rb_n = '0;
			end
			tc_n = '0;
			ph_n = PH_START_SDA;
		end

		ph_cur = ph_n;
		if (step && ph_cur != PH_IDLE) begin
			// apply pin levels on the first tick of a segment
			if (tc_n == '0) begin
				unique case (ph_cur)
					PH_START_SDA: begin sda_n = 1'b1; en_n = 1'b1; end
					PH_START_LOW: begin sda_n = 1'b0; en_n = 1'b1; end
					PH_TX_LOW: begin
						scl_n = 1'b0;
						sda_n = sb_n[bi_n];
						en_n  = 1'b1;
					end
					PH_ACK_LOW: begin scl_n = 1'b0; sda_n = 1'b1; en_n = 1'b1; end
					PH_RX_HIGH: begin scl_n = 1'b1; en_n = 1'b0; end
					PH_START_SCL, PH_TX_HIGH, PH_ACK_HIGH, PH_NK_HIGH, PH_STOP_B: begin
						scl_n = 1'b1;
					end
					PH_RX_LOW, PH_NK_LOW, PH_NK_END: begin
						scl_n = 1'b0;
					end
					PH_NK_SDA: begin sda_n = 1'b0; en_n = 1'b1; end
					PH_STOP_A: begin scl_n = 1'b0; sda_n = 1'b0; en_n = 1'b1; end
					PH_STOP_C: begin sda_n = 1'b1; en_n = 1'b1; end
					default: ;
				endcase
			end

			tc_inc = tc_n + 16'd1;
			if (tc_inc >= hold) begin
				tc_n = '0;
				unique case (ph_cur)
					PH_START_SDA: ph_n = PH_START_SCL;
					PH_START_SCL: ph_n = PH_START_LOW;
					PH_START_LOW: ph_n = PH_TX_LOW;
					PH_TX_LOW:    ph_n = PH_TX_HIGH;
					PH_TX_HIGH: begin
						if (bi_n != '0) begin
							bi_n = bi_n - 3'd1;
							ph_n = PH_TX_LOW;
						end else begin
							ph_n = PH_ACK_LOW;
						end
					end
					PH_ACK_LOW: ph_n = PH_ACK_HIGH;
					PH_ACK_HIGH: begin
						bi_n = LAST_BIT;
						if (bn_n == BYTE_ID) begin
							if (hc_n == CMD_READ) begin
								ph_n = PH_RX_LOW;
							end else begin
								sb_n = hs_n;
								bn_n = BYTE_SUB;
								ph_n = PH_TX_LOW;
							end
						end else if (bn_n == BYTE_SUB && hc_n == CMD_WRITE3) begin
							sb_n = hw_n;
							bn_n = BYTE_DATA;
							ph_n = PH_TX_LOW;
						end else begin
							ph_n = PH_STOP_A;
						end
					end
					PH_RX_LOW: ph_n = PH_RX_HIGH;
					PH_RX_HIGH: begin
						rb_n[bi_n] = rb_n[bi_n] | item.sda_in;
						if (bi_n != '0) begin
							bi_n = bi_n - 3'd1;
							ph_n = PH_RX_LOW;
						end else begin
							ph_n = PH_NK_LOW;
						end
					end
					PH_NK_LOW:  ph_n = PH_NK_HIGH;
					PH_NK_HIGH: ph_n = PH_NK_END;
					PH_NK_END:  ph_n = PH_NK_SDA;
					PH_NK_SDA:  ph_n = PH_STOP_A;
					PH_STOP_A:  ph_n = PH_STOP_B;
					PH_STOP_B:  ph_n = PH_STOP_C;
					default:    ph_n = PH_IDLE;
				endcase
				done = (ph_n == PH_IDLE);
			end else begin
				tc_n = tc_inc;
			end
		end
	end

	always_comb begin
		result.scl       = scl_n;
		result.sda_out   = sda_n;
		result.sda_drive = en_n;
		result.busy_res  = (ph_n != PH_IDLE);
		result.done_res  = done;
		result.read_data = rb_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			tc_q  <= '0;
			bi_q  <= '0;
			sb_q  <= '0;
			rb_q  <= '0;
			hc_q  <= '0;
			bn_q  <= BYTE_ID;
			hs_q  <= '0;
			hw_q  <= '0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			en_q  <= 1'b1;
		end else if (step) begin
			ph_q  <= ph_n;
			tc_q  <= tc_n;
			bi_q  <= bi_n;
			sb_q  <= sb_n;
			rb_q  <= rb_n;
			hc_q  <= hc_n;
			bn_q  <= bn_n;
			hs_q  <= hs_n;
			hw_q  <= hw_n;
			scl_q <= scl_n;
			sda_q <= sda_n;
			en_q  <= en_n;
		end
	end

endmodule

>>> hw/rtl/sccbms_checker.sv
// Port-level checks for the SCCB master sequencer, bound to the top level.
module sccbms_checker import sccbms_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// A stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	// An empty result register never backs up the input
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("input stalled with empty result register");

	// Completion ends the transaction
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |-> !result.busy_res)
		else $error("done while still busy");

	// SDA is released only inside a read transaction
	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.sda_drive |-> result.busy_res)
		else $error("SDA released while idle");

endmodule

bind sccb_master_sequencer_core sccbms_checker u_sccbms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

>>> tb/testbench.sv
// Self-checking testbench for sccb_master_sequencer_core: random bus ticks, pin-level predictor.
module testbench;
	import sccbms_pkg::*;

	// Upper bound on cycles with no word moving on any port. The longest quiet
	// stretch is the receiver hold-off plus a sender gap and a register-write pause.
	localparam int QUIET_LIMIT = 2000;
	localparam int NO_LIMIT    = 32'h7fffffff;

	// How sda_in is chosen for the ticks of one transfer.
	localparam int SDA_RANDOM = 0;
	localparam int SDA_HIGH   = 1;
	localparam int SDA_LOW    = 2;

	// Bus sequencer state, kept once for the generator and once for checking.
	typedef struct packed {
		phase_t      ph;
		logic [16:0] ticks;
		logic [3:0]  bit_idx;
		logic [7:0]  shifter;
		logic [7:0]  rx_byte;
		logic [1:0]  cmd;
		logic [7:0]  sub;
		logic [7:0]  dat;
		logic        scl;
		logic        sda;
		logic        drv;
		logic [1:0]  byte_sel;
	} bus_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        wait_we = 1'b0;
	logic [15:0] wait_data = '0;

	// Words waiting to be offered, and pin levels owed by the block in order.
	item_t       tick_words[$];
	result_t     pin_levels_due[$];

	bus_state_t  gen_state;
	bus_state_t  model_state;
	logic [15:0] gen_wait;
	logic [15:0] model_wait;
	int          gen_count = 0;
	int          words_taken = 0;
	int          fail_count = 0;

	sccb_master_sequencer_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.wait_we      (wait_we),
		.wait_data    (wait_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// One bus tick: latch a request if idle, apply the segment's pin levels on its
	// first tick, and advance to the next segment once the hold count runs out.
	task automatic sccb_tick(inout bus_state_t s, input item_t w, input logic [15:0] wt,
			output result_t r);
		logic [16:0] hold;
		logic        done;
		hold = (wt == 16'd0) ? 17'd1 : {1'b0, wt};
		done = 1'b0;
		// Requests with the reserved command, or while busy, fall through untouched.
		if (s.ph == PH_IDLE && w.start_request && w.command != CMD_RSVD) begin
			s.cmd = w.command;
			s.sub = w.sub_address;
			s.dat = w.write_data;
			s.shifter = {w.device_id, w.command == CMD_READ};
			s.bit_idx = {1'b0, LAST_BIT};
			s.byte_sel = BYTE_ID;
			// A read starts from a cleared byte rather than merging into the old one.
			if (w.command == CMD_READ)
				s.rx_byte = 8'd0;
			s.ticks = '0;
			s.ph = PH_START_SDA;
		end
		if (s.ph != PH_IDLE) begin
			if (s.ticks == 0) begin
				case (s.ph)
					PH_START_SDA: begin
						s.sda = 1'b1;
						s.drv = 1'b1;
					end
					PH_START_LOW: begin
						s.sda = 1'b0;
						s.drv = 1'b1;
					end
					PH_TX_LOW: begin
						s.scl = 1'b0;
						s.sda = s.shifter[s.bit_idx[2:0]];
						s.drv = 1'b1;
					end
					PH_ACK_LOW: begin
						s.scl = 1'b0;
						s.sda = 1'b1;
						s.drv = 1'b1;
					end
					PH_RX_HIGH: begin
						s.scl = 1'b1;
						s.drv = 1'b0;
					end
					PH_START_SCL, PH_TX_HIGH, PH_ACK_HIGH, PH_NK_HIGH, PH_STOP_B: begin
						s.scl = 1'b1;
					end
					PH_RX_LOW, PH_NK_LOW, PH_NK_END: begin
						s.scl = 1'b0;
					end
					PH_NK_SDA: begin
						s.sda = 1'b0;
						s.drv = 1'b1;
					end
					PH_STOP_A: begin
						s.scl = 1'b0;
						s.sda = 1'b0;
						s.drv = 1'b1;
					end
					PH_STOP_C: begin
						s.sda = 1'b1;
						s.drv = 1'b1;
					end
					default: begin
					end
				endcase
			end
			s.ticks = s.ticks + 17'd1;
			if (s.ticks >= hold) begin
				s.ticks = '0;
				case (s.ph)
					PH_START_SDA: s.ph = PH_START_SCL;
					PH_START_SCL: s.ph = PH_START_LOW;
					PH_START_LOW: s.ph = PH_TX_LOW;
					PH_TX_LOW:    s.ph = PH_TX_HIGH;
					PH_TX_HIGH: begin
						if (s.bit_idx != 0) begin
							s.bit_idx = s.bit_idx - 4'd1;
							s.ph = PH_TX_LOW;
						end else begin
							s.ph = PH_ACK_LOW;
						end
					end
					PH_ACK_LOW: s.ph = PH_ACK_HIGH;
					PH_ACK_HIGH: begin
						s.bit_idx = {1'b0, LAST_BIT};
						if (s.byte_sel == BYTE_ID) begin
							if (s.cmd == CMD_READ) begin
								s.ph = PH_RX_LOW;
							end else begin
								s.shifter = s.sub;
								s.byte_sel = BYTE_SUB;
								s.ph = PH_TX_LOW;
							end
						end else if (s.byte_sel == BYTE_SUB && s.cmd == CMD_WRITE3) begin
							s.shifter = s.dat;
							s.byte_sel = BYTE_DATA;
							s.ph = PH_TX_LOW;
						end else begin
							s.ph = PH_STOP_A;
						end
					end
					PH_RX_LOW: s.ph = PH_RX_HIGH;
					PH_RX_HIGH: begin
						// Sample SDA on the last tick of the high segment.
						s.rx_byte[s.bit_idx[2:0]] = s.rx_byte[s.bit_idx[2:0]] | w.sda_in;
						if (s.bit_idx != 0) begin
							s.bit_idx = s.bit_idx - 4'd1;
							s.ph = PH_RX_LOW;
						end else begin
							s.ph = PH_NK_LOW;
						end
					end
					PH_NK_LOW:  s.ph = PH_NK_HIGH;
					PH_NK_HIGH: s.ph = PH_NK_END;
					PH_NK_END:  s.ph = PH_NK_SDA;
					PH_NK_SDA:  s.ph = PH_STOP_A;
					PH_STOP_A:  s.ph = PH_STOP_B;
					PH_STOP_B:  s.ph = PH_STOP_C;
					default:    s.ph = PH_IDLE;
				endcase
				if (s.ph == PH_IDLE)
					done = 1'b1;
			end
		end
		r.scl = s.scl;
		r.sda_out = s.sda;
		r.sda_drive = s.drv;
		r.busy_res = (s.ph != PH_IDLE);
		r.done_res = done;
		r.read_data = s.rx_byte;
	endtask

	task automatic bus_reset(output bus_state_t s);
		s = '0;
		s.ph = PH_IDLE;
		s.scl = 1'b1;
		s.sda = 1'b1;
		s.drv = 1'b1;
	endtask

	// Queue a word and run it through the generator's copy of the sequencer, so
	// that the generator knows when the bus is free again.
	task automatic queue_word(input item_t w);
		result_t dummy;
		sccb_tick(gen_state, w, gen_wait, dummy);
		tick_words.push_back(w);
		gen_count++;
	endtask

	// A tick during a transfer: random operands, and now and then a request that
	// must be ignored because the bus is busy.
	function automatic item_t filler_word(int sda_mode);
		item_t w;
		w.start_request = ($urandom_range(0, 3) == 0);
		w.command = 2'($urandom_range(0, 3));
		w.device_id = 7'($urandom_range(0, 127));
		w.sub_address = 8'($urandom_range(0, 255));
		w.write_data = 8'($urandom_range(0, 255));
		if (sda_mode == SDA_HIGH)
			w.sda_in = 1'b1;
		else if (sda_mode == SDA_LOW)
			w.sda_in = 1'b0;
		else
			w.sda_in = 1'($urandom_range(0, 1));
		return w;
	endfunction

	// An idle tick; only a reserved-command request may ride along.
	function automatic item_t idle_word();
		item_t w;
		w = filler_word(SDA_RANDOM);
		if (w.command != CMD_RSVD)
			w.start_request = 1'b0;
		return w;
	endfunction

	// Issue one request and follow it with ticks until the bus is idle again or
	// max_fill ticks have gone by.
	task automatic run_transfer(input logic [1:0] cmd, input logic [6:0] id,
			input logic [7:0] sub, input logic [7:0] dat, input int sda_mode, input int max_fill);
		item_t w;
		int    n;
		w = filler_word(sda_mode);
		w.start_request = 1'b1;
		w.command = cmd;
		w.device_id = id;
		w.sub_address = sub;
		w.write_data = dat;
		queue_word(w);
		n = 0;
		while (gen_state.ph != PH_IDLE && n < max_fill) begin
			queue_word(filler_word(sda_mode));
			n++;
		end
		// Sometimes the next request lands on the very tick after done.
		if (gen_state.ph == PH_IDLE)
			repeat ($urandom_range(0, 2)) queue_word(idle_word());
	endtask

	task automatic random_transfer();
		int mode;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6)) queue_word(idle_word());
		end else begin
			mode = ($urandom_range(0, 3) == 0) ? int'($urandom_range(SDA_HIGH, SDA_LOW))
				: SDA_RANDOM;
			run_transfer(2'($urandom_range(0, 2)), 7'($urandom_range(0, 127)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), mode, NO_LIMIT);
		end
	endtask

	task automatic random_phase(input int n);
		int start;
		start = gen_count;
		while (gen_count - start < n)
			random_transfer();
	endtask

	// Wait for every queued word to be taken and every owed word to come back,
	// then give the two pipeline stages time to empty.
	task automatic settle();
		while (tick_words.size() != 0 || item_valid || pin_levels_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_wait(input logic [15:0] v);
		settle();
		wait_we <= 1'b1;
		wait_data <= v;
		@(posedge clk);
		wait_we <= 1'b0;
		gen_wait = v;
		model_wait = v;
	endtask

	task automatic report_mismatch(input string field, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t: %s got %0h expected %0h", $time, field, got, want);
		fail_count++;
	endtask

	// Sender: offer queued words in bursts, with random gaps between bursts.
	// A stalled word is held as it is.
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || !item_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (tick_words.size() != 0) begin
				item <= tick_words.pop_front();
				item_valid <= 1'b1;
				if (burst_left <= 1) begin
					// Mostly short bursts; now and then a long run with no gap at all.
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
						: $urandom_range(1, 12);
					gap_left = $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall at a rate drawn anew after each random-length run, and once hold
	// off for a long stretch so that both pipeline stages fill and the input stalls.
	int stall_pct = 0;
	int pattern_left = 0;
	int holdoff_left = 0;
	bit holdoff_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (holdoff_left > 0) begin
			holdoff_left--;
			result_stall <= 1'b1;
		end else if (!holdoff_done && words_taken >= 650) begin
			holdoff_done = 1'b1;
			holdoff_left = 90;
			result_stall <= 1'b1;
		end else begin
			if (pattern_left == 0) begin
				case ($urandom_range(0, 4))
					0, 1:    stall_pct = 0;
					2:       stall_pct = 20;
					3:       stall_pct = 50;
					default: stall_pct = 80;
				endcase
				pattern_left = $urandom_range(20, 100);
			end else begin
				pattern_left--;
			end
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Monitor: predict pin levels for each word taken in, and check each word that
	// comes out against the oldest prediction.
	result_t predicted;
	result_t owed;

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				sccb_tick(model_state, item, model_wait, predicted);
				pin_levels_due.push_back(predicted);
				words_taken++;
			end
			if (result_valid && !result_stall) begin
				if (pin_levels_due.size() == 0) begin
					report_mismatch("result word with nothing owed", 8'd1, 8'd0);
				end else begin
					owed = pin_levels_due.pop_front();
					if (result.scl !== owed.scl)
						report_mismatch("scl", 8'(result.scl), 8'(owed.scl));
					if (result.sda_out !== owed.sda_out)
						report_mismatch("sda_out", 8'(result.sda_out), 8'(owed.sda_out));
					if (result.sda_drive !== owed.sda_drive)
						report_mismatch("sda_drive", 8'(result.sda_drive),
							8'(owed.sda_drive));
					if (result.busy_res !== owed.busy_res)
						report_mismatch("busy_res", 8'(result.busy_res), 8'(owed.busy_res));
					if (result.done_res !== owed.done_res)
						report_mismatch("done_res", 8'(result.done_res), 8'(owed.done_res));
					if (result.read_data !== owed.read_data)
						report_mismatch("read_data", result.read_data, owed.read_data);
				end
			end
		end
	end

	// Watchdog: drop the run if nothing moves for too long.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) || wait_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[sccb_master_sequencer_core] ERROR");
				$finish;
			end
		end
	end

	initial begin
		item_t w;
		bus_reset(gen_state);
		bus_reset(model_state);
		gen_wait = WAIT_RESET;
		model_wait = WAIT_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset hold count: a quiet tick, a reserved-command request, then part of
		// a slow write.
		w = '0;
		queue_word(w);
		w = '1;
		w.command = CMD_RSVD;
		queue_word(w);
		run_transfer(CMD_WRITE2, 7'h7F, 8'h00, 8'hFF, SDA_RANDOM, 150);

		// Zero hold count behaves as one; finish the write left in flight.
		load_wait(16'd0);
		while (gen_state.ph != PH_IDLE)
			queue_word(filler_word(SDA_RANDOM));

		// Every command with operand extremes; two reads back to back check that
		// the read byte is cleared rather than merged.
		run_transfer(CMD_WRITE3, 7'h7F, 8'hFF, 8'h00, SDA_RANDOM, NO_LIMIT);
		run_transfer(CMD_WRITE3, 7'h00, 8'h00, 8'hFF, SDA_LOW, NO_LIMIT);
		run_transfer(CMD_WRITE2, 7'h55, 8'hA5, 8'h5A, SDA_HIGH, NO_LIMIT);
		run_transfer(CMD_READ, 7'h2A, 8'h00, 8'h00, SDA_HIGH, NO_LIMIT);
		run_transfer(CMD_READ, 7'h7F, 8'hFF, 8'hFF, SDA_LOW, NO_LIMIT);
		run_transfer(CMD_READ, 7'h00, 8'h3C, 8'hC3, SDA_RANDOM, NO_LIMIT);

		// Random transfers at several bus speeds. The longest hold count only sees
		// the start of a read; the next speed picks it up mid-segment.
		load_wait(16'd1);
		random_phase(120);
		load_wait(16'hFFFF);
		run_transfer(CMD_READ, 7'($urandom_range(0, 127)), 8'h00, 8'h00, SDA_RANDOM, 40);
		load_wait(16'd2);
		while (gen_state.ph != PH_IDLE)
			queue_word(filler_word(SDA_RANDOM));
		random_phase(60);

		settle();
		if (fail_count == 0)
			$display("[sccb_master_sequencer_core] OK");
		else
			$display("[sccb_master_sequencer_core] ERROR");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/sccbms_pkg.sv
hw/rtl/sccbms_core.sv
hw/rtl/sccb_master_sequencer_core.sv
hw/rtl/sccbms_checker.sv
tb/testbench.sv
